// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the display formatter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, masked while reset is high.
`define DSF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DSF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: sv/dsf_pkg.sv
// ----------------------------------------------------------------------------
// Display formatter package
// Request codes, command bytes, glyph table and digit split shared by the core.
// ----------------------------------------------------------------------------
package dsf_pkg;

   localparam int FRAME_LEN = 5;

   typedef enum logic [2:0] {
      REQ_INIT   = 3'd0,
      REQ_NUMBER = 3'd1,
      REQ_TIME   = 3'd2,
      REQ_COLON  = 3'd3,
      REQ_SIGNED = 3'd4,
      REQ_OFF    = 3'd5,
      REQ_BRIGHT = 3'd6
   } req_kind_type;

   localparam logic [7:0]  CMD_DATA     = 8'h40;
   localparam logic [7:0]  CMD_DISPLAY  = 8'h80;
   localparam logic [7:0]  CMD_ADDR     = 8'hC0;
   localparam logic [7:0]  CMD_ENABLE   = 8'h08;
   localparam logic [2:0]  BRIGHT_MAX   = 3'd7;
   localparam logic [2:0]  BRIGHT_RESET = 3'd2;
   localparam logic [13:0] NUM_MAX      = 14'd9999;
   localparam logic [13:0] NEG_MAX      = 14'd999;
   localparam logic [7:0]  SEG_MINUS    = 8'h40;
   localparam logic [7:0]  SEG_DARK     = 8'h00;
   localparam logic [7:0]  SEG_DP       = 8'h80;

   // index 0 is the leftmost (thousands) digit
   typedef logic [3:0][3:0] bcd_type;

   typedef struct packed {
      logic [FRAME_LEN-1:0][7:0] bytes;
      logic [FRAME_LEN-1:0]      start;
      logic [FRAME_LEN-1:0]      stop;
      logic [2:0]                count;
   } frame_type;

   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] g;
      case (d)
         4'd0:    g = 8'h3F;
         4'd1:    g = 8'h06;
         4'd2:    g = 8'h5B;
         4'd3:    g = 8'h4F;
         4'd4:    g = 8'h66;
         4'd5:    g = 8'h6D;
         4'd6:    g = 8'h7D;
         4'd7:    g = 8'h07;
         4'd8:    g = 8'h7F;
         4'd9:    g = 8'h6F;
         default: g = SEG_DARK;
      endcase
      return g;
   endfunction

   // Value is at most 9999: one compare-and-subtract rank per decade.
   function automatic bcd_type split_bcd(input logic [13:0] v);
      bcd_type     d;
      logic [13:0] r1;
      logic [13:0] r2;
      logic [13:0] r3;
      d  = '0;
      r1 = v;
      for (int k = 1; k < 10; k++) begin
         if (v >= 14'(k * 1000)) begin
            d[0] = 4'(k);
            r1   = v - 14'(k * 1000);
         end
      end
      r2 = r1;
      for (int k = 1; k < 10; k++) begin
         if (r1 >= 14'(k * 100)) begin
            d[1] = 4'(k);
            r2   = r1 - 14'(k * 100);
         end
      end
      r3 = r2;
      for (int k = 1; k < 10; k++) begin
         if (r2 >= 14'(k * 10)) begin
            d[2] = 4'(k);
            r3   = r2 - 14'(k * 10);
         end
      end
      d[3] = r3[3:0];
      return d;
   endfunction

endpackage

// File: sv/dsf_format.sv
// ----------------------------------------------------------------------------
// Display formatter frame builder
// Turns one registered request into the bytes and frame flags it emits, plus any brightness update.
// ----------------------------------------------------------------------------
module dsf_format (
   input  logic [2:0]         kind,
   input  logic [15:0]        value,
   input  logic [7:0]         level,
   input  logic [2:0]         bright,
   output dsf_pkg::frame_type frame,
   output logic               bright_we,
   output logic [2:0]         bright_new
);
   import dsf_pkg::*;

   logic        neg;
   logic [16:0] mag;
   logic [13:0] num;
   bcd_type     bcd;
   logic [3:0][7:0] seg;

   assign neg = value[15];
   assign mag = 17'h10000 - {1'b0, value};
   assign bright_new = (level > 8'(BRIGHT_MAX)) ? BRIGHT_MAX : level[2:0];

   always_comb begin
      if (kind == REQ_SIGNED && neg) begin
         num = (mag > 17'(NEG_MAX)) ? NEG_MAX : mag[13:0];
      end else begin
         num = (value > 16'(NUM_MAX)) ? NUM_MAX : value[13:0];
      end
   end

   assign bcd = split_bcd(num);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         seg[i] = glyph(bcd[i]);
      end
      case (req_kind_type'(kind))
         REQ_TIME, REQ_COLON: begin
            seg[1] = seg[1] | SEG_DP;
         end
         REQ_SIGNED: begin
            if (neg) begin
               if (num >= 14'd100) begin
                  seg[0] = SEG_MINUS;
               end else if (num >= 14'd10) begin
                  seg[0] = SEG_DARK;
                  seg[1] = SEG_MINUS;
               end else begin
                  seg[0] = SEG_DARK;
                  seg[1] = SEG_DARK;
                  seg[2] = SEG_MINUS;
               end
            end else begin
               if (num < 14'd1000) seg[0] = SEG_DARK;
               if (num < 14'd100)  seg[1] = SEG_DARK;
               if (num < 14'd10)   seg[2] = SEG_DARK;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      frame     = '0;
      bright_we = 1'b0;
      case (req_kind_type'(kind))
         REQ_INIT: begin
            frame.bytes[0] = CMD_DATA;
            frame.bytes[1] = CMD_DISPLAY | CMD_ENABLE | {5'd0, bright};
            frame.start    = 5'b00011;
            frame.stop     = 5'b00011;
            frame.count    = 3'd2;
         end
         REQ_NUMBER, REQ_TIME, REQ_COLON, REQ_SIGNED: begin
            frame.bytes[0] = CMD_ADDR;
            for (int i = 0; i < 4; i++) begin
               frame.bytes[i+1] = seg[i];
            end
            frame.start = 5'b00001;
            frame.stop  = 5'b10000;
            frame.count = 3'(FRAME_LEN);
         end
         REQ_OFF: begin
            frame.bytes[0] = CMD_DISPLAY | {5'd0, bright};
            frame.start    = 5'b00001;
            frame.stop     = 5'b00001;
            frame.count    = 3'd1;
         end
         REQ_BRIGHT: begin
            frame.bytes[0] = CMD_DISPLAY | CMD_ENABLE | {5'd0, bright_new};
            frame.start    = 5'b00001;
            frame.stop     = 5'b00001;
            frame.count    = 3'd1;
            bright_we      = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: sv/dsf_emit.sv
// ----------------------------------------------------------------------------
// Display formatter byte emitter
// Holds one built frame and hands its bytes out one word per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsf_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_valid,
   input  dsf_pkg::frame_type load_frame,
   output logic               load_free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,  // [7:0] wire_byte
   output logic [1:0]         rsp_tuser,  // [0] frame_start, [1] frame_end
   output logic               rsp_tlast   // last
);
   import dsf_pkg::*;

   frame_type  frm_ff, frm_in;
   logic [2:0] pos_ff, pos_in;
   logic       vld_ff, vld_in;
   logic       fire;
   logic       at_end;
   logic       load;

   assign at_end    = (pos_ff == (frm_ff.count - 3'd1));
   assign fire      = vld_ff && rsp_tready;
   assign load_free = !vld_ff || (fire && at_end);
   assign load      = load_valid && load_free;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = frm_ff.bytes[pos_ff];
   assign rsp_tuser  = {frm_ff.stop[pos_ff], frm_ff.start[pos_ff]};
   assign rsp_tlast  = at_end;

   always_comb begin
      frm_in = frm_ff;
      pos_in = pos_ff;
      vld_in = vld_ff;
      if (load) begin
         frm_in = load_frame;
         pos_in = 3'd0;
         vld_in = (load_frame.count != 3'd0);
      end else if (fire) begin
         if (at_end) begin
            vld_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         pos_ff <= 3'd0;
      end else begin
         vld_ff <= vld_in;
         pos_ff <= pos_in;
      end
      frm_ff <= frm_in;
   end

   `DSF_ASSERT(a_pos_in_frame, vld_ff |-> (pos_ff < frm_ff.count), "byte index past frame end")
   `DSF_ASSERT(a_frame_continues, (fire && !at_end) |=> vld_ff, "frame dropped before its last byte")
   `DSF_ASSERT(a_load_only_free, (load && vld_ff) |-> (fire && at_end), "frame overwritten in flight")

endmodule

// File: sv/four_digit_segment_display_formatter_core.sv
// ----------------------------------------------------------------------------
// Four-digit seven-segment display formatter core
// Turns display requests into framed command and segment bytes for a
// two-wire 4-digit display controller.
// ----------------------------------------------------------------------------
// Path: an accepted request waits in the request slot, then loads into the frame buffer,
// which drives its first byte. Throughput: one byte per cycle while rsp_tready is high;
// a request yields 1, 2 or 5 bytes (brightness/off, init, digit frames).
// A request slot and a frame buffer let the next request wait behind a frame.
// Reset: synchronous, active high; empties both stages, brightness returns to 2.
`include "assert_macros.svh"

module four_digit_segment_display_formatter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] value_bits, [23:16] brightness_level
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] wire_byte
   output logic [1:0]  rsp_tuser,   // [0] frame_start, [1] frame_end
   output logic        rsp_tlast    // last
);
   import dsf_pkg::*;

   // Request slot: one word held until the frame buffer takes it.
   logic        s1_vld_ff, s1_vld_in;
   logic [2:0]  s1_kind_ff, s1_kind_in;
   logic [15:0] s1_value_ff, s1_value_in;
   logic [7:0]  s1_level_ff, s1_level_in;

   // Stored brightness, updated in request order as a frame is built.
   logic [2:0]  bright_ff, bright_in;

   frame_type   frame;
   logic        bright_we;
   logic [2:0]  bright_new;
   logic        load_free;
   logic        s1_move;
   logic        req_fire;

   assign s1_move    = s1_vld_ff && load_free;
   assign req_tready = !s1_vld_ff || load_free;
   assign req_fire   = req_tvalid && req_tready;

   // Build the whole frame in one pass from the slot contents.
   dsf_format u_format (
      .kind       (s1_kind_ff),
      .value      (s1_value_ff),
      .level      (s1_level_ff),
      .bright     (bright_ff),
      .frame      (frame),
      .bright_we  (bright_we),
      .bright_new (bright_new)
   );

   // Hold the frame and stream its bytes; an unused request code builds
   // an empty frame and is dropped here without any output word.
   dsf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s1_vld_ff),
      .load_frame (frame),
      .load_free  (load_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      s1_vld_in   = s1_vld_ff;
      s1_kind_in  = s1_kind_ff;
      s1_value_in = s1_value_ff;
      s1_level_in = s1_level_ff;
      bright_in   = bright_ff;
      if (s1_move) begin
         s1_vld_in = 1'b0;
         if (bright_we) begin
            bright_in = bright_new;
         end
      end
      // Capture a new word; this wins over the drain of the old one.
      if (req_fire) begin
         s1_vld_in   = 1'b1;
         s1_kind_in  = req_tuser;
         s1_value_in = req_tdata[15:0];
         s1_level_in = req_tdata[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         bright_ff <= BRIGHT_RESET;
      end else begin
         s1_vld_ff <= s1_vld_in;
         bright_ff <= bright_in;
      end
      s1_kind_ff  <= s1_kind_in;
      s1_value_ff <= s1_value_in;
      s1_level_ff <= s1_level_in;
   end

   `DSF_ASSERT(a_slot_holds, (s1_vld_ff && !load_free) |=> s1_vld_ff, "stalled request lost")
   `DSF_ASSERT(a_bright_order, (bright_ff != $past(bright_ff)) |-> $past(s1_move && bright_we), "brightness changed outside a brightness request")
   `DSF_ASSERT_ALWAYS(a_reset_empties, $past(reset) |-> (!s1_vld_ff && !rsp_tvalid), "reset left a word in flight")

endmodule

// File: test/tb_four_digit_segment_display_formatter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display formatter core testbench
// Sends directed and random display requests through the request stream and
// checks every framed command and segment word on the response stream against
// a cycle-free model of the formatter, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_four_digit_segment_display_formatter_core;
   import dsf_pkg::*;

   // Type 7 is not a request: the core must swallow it without a word.
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // Segment patterns for 0..9, bits DP G F E D C B A.
   localparam logic [9:0][7:0] SEG_GLYPH = {
      8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   localparam int RANDOM_REQS = 195;
   localparam int TAIL_REQS   = 40;   // no idling once this few are left
   localparam int STALL_AFTER = 40;   // words taken before the long hold-off
   localparam int STALL_LEN   = 160;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic [7:0]  level;
   } display_req_type;

   typedef struct packed {
      logic [7:0] seg_byte;
      logic       start;
      logic       stop;
      logic       last;
   } wire_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [15:0] value_bits, [23:16] brightness_level
   logic [2:0]  req_tuser  = '0;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] wire_byte
   logic [1:0]  rsp_tuser;         // [0] frame_start, [1] frame_end
   logic        rsp_tlast;

   display_req_type display_requests[$];
   wire_word_type   due_words[$];
   logic [2:0]      disp_bright = BRIGHT_RESET;
   logic            quiet_tail  = 1'b0;
   int              mismatches  = 0;

   // driver-side bookkeeping
   int send_gap    = 0;
   int reqs_taken  = 0;
   // receiver-side bookkeeping
   int take_gap    = 0;
   int words_taken = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   four_digit_segment_display_formatter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   function automatic void push_word(input logic [7:0] b, input logic st, input logic en,
                                     input logic lst);
      wire_word_type w;
      w.seg_byte = b;
      w.start    = st;
      w.stop     = en;
      w.last     = lst;
      due_words.push_back(w);
   endfunction

   // Address byte, then the four digits from thousands down to units.
   function automatic void push_digit_frame(input logic [3:0][7:0] dig);
      push_word(CMD_ADDR, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++)
         push_word(dig[i], 1'b0, i == 3, i == 3);
   endfunction

   function automatic logic [3:0][7:0] glyphs_of(input int v);
      logic [3:0][7:0] dig;
      dig[0] = SEG_GLYPH[(v / 1000) % 10];
      dig[1] = SEG_GLYPH[(v / 100) % 10];
      dig[2] = SEG_GLYPH[(v / 10) % 10];
      dig[3] = SEG_GLYPH[v % 10];
      return dig;
   endfunction

   // Work out the words one accepted request must produce, and track brightness.
   function automatic void format_request(input logic [2:0] kind, input logic [15:0] value,
                                          input logic [7:0] level);
      logic [3:0][7:0] dig;
      int              mag;
      case (kind)
         REQ_INIT: begin
            push_word(CMD_DATA, 1'b1, 1'b1, 1'b0);
            push_word(CMD_DISPLAY | CMD_ENABLE | {5'd0, disp_bright}, 1'b1, 1'b1, 1'b1);
         end
         REQ_NUMBER, REQ_TIME, REQ_COLON: begin
            mag = (int'(value) > 9999) ? 9999 : int'(value);
            dig = glyphs_of(mag);
            if (kind != REQ_NUMBER)
               dig[1] = dig[1] | SEG_DP;
            push_digit_frame(dig);
         end
         REQ_SIGNED: begin
            if (value[15]) begin
               mag = 65536 - int'(value);
               if (mag > 999)
                  mag = 999;
               dig = glyphs_of(mag);
               // minus sits just left of the top significant digit
               if (mag >= 100) begin
                  dig[0] = SEG_MINUS;
               end else if (mag >= 10) begin
                  dig[0] = SEG_DARK;
                  dig[1] = SEG_MINUS;
               end else begin
                  dig[0] = SEG_DARK;
                  dig[1] = SEG_DARK;
                  dig[2] = SEG_MINUS;
               end
            end else begin
               mag = (int'(value) > 9999) ? 9999 : int'(value);
               dig = glyphs_of(mag);
               if (mag < 1000) dig[0] = SEG_DARK;
               if (mag < 100)  dig[1] = SEG_DARK;
               if (mag < 10)   dig[2] = SEG_DARK;
            end
            push_digit_frame(dig);
         end
         REQ_OFF: begin
            push_word(CMD_DISPLAY | {5'd0, disp_bright}, 1'b1, 1'b1, 1'b1);
         end
         REQ_BRIGHT: begin
            disp_bright = (level > 8'(BRIGHT_MAX)) ? BRIGHT_MAX : level[2:0];
            push_word(CMD_DISPLAY | CMD_ENABLE | {5'd0, disp_bright}, 1'b1, 1'b1, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic display_req_type make_req(input logic [2:0] kind,
                                                input logic [15:0] value,
                                                input logic [7:0] level);
      display_req_type r;
      r.kind  = kind;
      r.value = value;
      r.level = level;
      return r;
   endfunction

   // Mostly real requests; values lean towards clamp and blanking boundaries.
   function automatic display_req_type random_req();
      display_req_type r;
      logic [15:0]     edges [12];
      edges = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999,
                16'd10000, 16'hFC19, 16'hFC18, 16'h8000};
      if ($urandom_range(0, 99) < 6)
         r.kind = REQ_UNUSED;
      else
         r.kind = 3'($urandom_range(0, 6));
      case ($urandom_range(0, 4))
         0:       r.value = 16'($urandom_range(0, 9999));
         1:       r.value = 16'($urandom);
         2:       r.value = 16'($urandom_range(0, 120));
         3:       r.value = 16'(-int'($urandom_range(1, 1100)));
         default: r.value = edges[$urandom_range(0, 11)];
      endcase
      r.level = $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom);
      return r;
   endfunction

   // Request side: offer queued requests, with random gaps between them.
   always @(posedge clock) begin : drive_requests
      display_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            format_request(req_tuser, req_tdata[15:0], req_tdata[23:16]);
            reqs_taken++;
            // idle in bursts, but leave every third stretch of requests clean
            if (!quiet_tail && (reqs_taken / 30) % 3 != 2 && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 11);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (display_requests.size() > 0) begin
               nxt = display_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.level, nxt.value};
               req_tuser  <= nxt.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         quiet_tail <= display_requests.size() < TAIL_REQS;
      end
   end

   // Response side: random stalls, plus one long hold-off to fill the core.
   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            words_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && words_taken >= STALL_AFTER) begin
            hold_done = 1'b1;
            hold_left = STALL_LEN;
            rsp_tready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet_tail && (words_taken / 25) % 3 != 1 && $urandom_range(0, 3) == 0)
               take_gap = $urandom_range(1, 11);
         end
      end
   end

   // Compare each accepted word with the oldest one due.
   always @(posedge clock) begin : check_words
      wire_word_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            $error("unexpected word: wire_byte %h", rsp_tdata);
            mismatches++;
         end else begin
            due = due_words.pop_front();
            if (rsp_tdata !== due.seg_byte) begin
               $error("wire_byte: expected %h, got %h", due.seg_byte, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser[0] !== due.start) begin
               $error("frame_start: expected %b, got %b", due.start, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== due.stop) begin
               $error("frame_end: expected %b, got %b", due.stop, rsp_tuser[1]);
               mismatches++;
            end
            if (rsp_tlast !== due.last) begin
               $error("last: expected %b, got %b", due.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin : run_control
      // directed: brightness path, clamps, time/colon point, signed blanking
      display_requests.push_back(make_req(REQ_INIT,   16'd0,      8'd0));
      display_requests.push_back(make_req(REQ_NUMBER, 16'd0,      8'd0));
      display_requests.push_back(make_req(REQ_NUMBER, 16'hFFFF,   8'd0));
      display_requests.push_back(make_req(REQ_NUMBER, 16'd1234,   8'd0));
      display_requests.push_back(make_req(REQ_TIME,   16'd5999,   8'd0));
      display_requests.push_back(make_req(REQ_COLON,  16'd10000,  8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'd0,      8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'd7,      8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'd42,     8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'd305,    8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'h7FFF,   8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'hFFFF,   8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'(-10),   8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'(-100),  8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'(-999),  8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'h8000,   8'd0));
      display_requests.push_back(make_req(REQ_OFF,    16'd0,      8'd0));
      display_requests.push_back(make_req(REQ_BRIGHT, 16'd0,      8'hFF));
      display_requests.push_back(make_req(REQ_INIT,   16'hFFFF,   8'hFF));
      display_requests.push_back(make_req(REQ_BRIGHT, 16'hFFFF,   8'd0));
      display_requests.push_back(make_req(REQ_OFF,    16'hFFFF,   8'hFF));
      display_requests.push_back(make_req(REQ_UNUSED, 16'hFFFF,   8'hFF));
      display_requests.push_back(make_req(REQ_BRIGHT, 16'd0,      8'd5));
      display_requests.push_back(make_req(REQ_NUMBER, 16'd9999,   8'd0));
      display_requests.push_back(make_req(REQ_SIGNED, 16'd1000,   8'd0));
      for (int i = 0; i < RANDOM_REQS; i++)
         display_requests.push_back(random_req());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for every request to go in and every due word to come out
      do
         @(negedge clock);
      while (reset || display_requests.size() != 0 || req_tvalid || due_words.size() != 0);
      // give an ignored request time to show a stray word
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
